// ===== rtl/clr_pkg.sv =====
package clr_pkg;

	localparam int VIEW_WIDTH_DEF  = 64;
	localparam int VIEW_HEIGHT_DEF = 64;
	localparam int CLIP_ROUNDS_DEF = 8;

	localparam int IN_W      = 16;
	localparam int COORD_W   = 18;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int FRAC_BITS = 4;
	localparam int PIX_W     = 6;
	localparam int ERR_W     = PIX_W + 3;

	localparam int DIV_STEPS   = 18;
	localparam int DIV_PER_CYC = 2;
	localparam int DIV_CYC     = DIV_STEPS / DIV_PER_CYC;
	localparam int DIV_CNT_W   = $clog2(DIV_CYC);
	localparam int REM_W       = COORD_W + 1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [3:0] OC_LEFT   = 4'd1;
	localparam logic [3:0] OC_RIGHT  = 4'd2;
	localparam logic [3:0] OC_TOP    = 4'd4;
	localparam logic [3:0] OC_BOTTOM = 4'd8;

	typedef struct packed {
		logic signed [IN_W-1:0] start_x;
		logic signed [IN_W-1:0] start_y;
		logic signed [IN_W-1:0] end_x;
		logic signed [IN_W-1:0] end_y;
	} seg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
		logic             last_pixel;
	} pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] px;
		logic [PIX_W-1:0] py;
		logic [PIX_W-1:0] qx;
		logic [PIX_W-1:0] qy;
	} line_t;

	function automatic logic signed [COORD_W-1:0] ext_coord(input logic signed [IN_W-1:0] v);
		ext_coord = {{(COORD_W-IN_W){v[IN_W-1]}}, v};
	endfunction

endpackage

// ===== rtl/clr_clip.sv =====
module clr_clip import clr_pkg::*; #(
	parameter int VIEW_WIDTH  = VIEW_WIDTH_DEF,
	parameter int VIEW_HEIGHT = VIEW_HEIGHT_DEF,
	parameter int CLIP_ROUNDS = CLIP_ROUNDS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  seg_valid,
	output logic  seg_stall,
	input  seg_t  seg,
	output logic  line_valid,
	input  logic  line_full,
	output line_t line
);

	localparam logic signed [COORD_W-1:0] XMAX = COORD_W'((VIEW_WIDTH - 1) * 16);
	localparam logic signed [COORD_W-1:0] YMAX = COORD_W'((VIEW_HEIGHT - 1) * 16);
	localparam int RND_W = $clog2(CLIP_ROUNDS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLASS = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_PREP  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_UPD   = 3'd5;
	localparam logic [2:0] ST_PUSH  = 3'd6;

	logic [2:0]                state_q;
	logic [RND_W-1:0]          rnd_q;
	logic [DIV_CNT_W-1:0]      step_q;
	logic signed [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [COORD_W-1:0] mul_a_q, mul_b_q, den_q, base_q, edge_q;
	logic                      use_y_q, pick_b_q, neg_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [REM_W-1:0]          rem_q, dvs_q;
	logic [DIV_STEPS-1:0]      num_q, quo_q;
	line_t                     line_q;

	function automatic logic [3:0] outcode(input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y);
		logic [3:0] c;
		c = 4'd0;
		if (x < 0) c = c | OC_LEFT;
		else if (x > XMAX) c = c | OC_RIGHT;
		if (y < 0) c = c | OC_TOP;
		else if (y > YMAX) c = c | OC_BOTTOM;
		outcode = c;
	endfunction

	function automatic logic [PIX_W-1:0] to_pix(input logic signed [COORD_W-1:0] v);
		logic [COORD_W-1:0] s;
		s = v + COORD_W'(8);
		to_pix = s[FRAC_BITS+PIX_W-1:FRAC_BITS];
	endfunction

	logic [3:0]                c0, c1, pick;
	logic                      use_y;
	logic signed [COORD_W-1:0] edge_v, da, db, b0, a0;

	always_comb begin
		c0 = outcode(ax_q, ay_q);
		c1 = outcode(bx_q, by_q);
		pick = (c0 != 4'd0) ? c0 : c1;
		use_y = |(pick & (OC_BOTTOM | OC_TOP));
		if (use_y) begin
			edge_v = ((pick & OC_BOTTOM) != 4'd0) ? YMAX : '0;
			da = bx_q - ax_q;
			db = by_q - ay_q;
			b0 = ay_q;
			a0 = ax_q;
		end else begin
			edge_v = ((pick & OC_RIGHT) != 4'd0) ? XMAX : '0;
			da = by_q - ay_q;
			db = bx_q - ax_q;
			b0 = ax_q;
			a0 = ay_q;
		end
	end

	logic [PROD_W-1:0]    abs_p;
	logic [COORD_W-1:0]   abs_d;
	logic [PROD_W:0]      nval;

	always_comb begin
		abs_p = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
		abs_d = den_q[COORD_W-1] ? COORD_W'(-den_q) : COORD_W'(den_q);
		nval = {abs_p, 1'b0} + (PROD_W+1)'(abs_d);
	end

	logic [REM_W-1:0]       r_div;
	logic [DIV_STEPS-1:0]   n_div, q_div;

	always_comb begin
		r_div = rem_q;
		n_div = num_q;
		q_div = quo_q;
		for (int i = 0; i < DIV_PER_CYC; i++) begin
			r_div = {r_div[REM_W-2:0], n_div[DIV_STEPS-1]};
			n_div = {n_div[DIV_STEPS-2:0], 1'b0};
			if (r_div >= dvs_q) begin
				r_div = r_div - dvs_q;
				q_div = {q_div[DIV_STEPS-2:0], 1'b1};
			end else begin
				q_div = {q_div[DIV_STEPS-2:0], 1'b0};
			end
		end
	end

	logic signed [COORD_W:0]   q_s;
	logic signed [COORD_W-1:0] other;

	always_comb begin
		q_s = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		other = COORD_W'({base_q[COORD_W-1], base_q} + q_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
			step_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (seg_valid) begin
						ax_q <= ext_coord(seg.start_x);
						ay_q <= ext_coord(seg.start_y);
						bx_q <= ext_coord(seg.end_x);
						by_q <= ext_coord(seg.end_y);
						rnd_q <= '0;
						state_q <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					if (rnd_q == RND_W'(CLIP_ROUNDS)) begin
						state_q <= ST_IDLE;
					end else if ((c0 | c1) == 4'd0) begin
						line_q <= '{px: to_pix(ax_q), py: to_pix(ay_q),
							qx: to_pix(bx_q), qy: to_pix(by_q)};
						state_q <= ST_PUSH;
					end else if ((c0 & c1) != 4'd0 || db == '0) begin
						state_q <= ST_IDLE;
					end else begin
						mul_a_q <= da;
						mul_b_q <= edge_v - b0;
						den_q <= db;
						base_q <= a0;
						edge_q <= edge_v;
						use_y_q <= use_y;
						pick_b_q <= (c0 == 4'd0);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= mul_a_q * mul_b_q;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					neg_q <= prod_q[PROD_W-1] ^ den_q[COORD_W-1];
					rem_q <= REM_W'(nval >> DIV_STEPS);
					num_q <= nval[DIV_STEPS-1:0];
					dvs_q <= {abs_d, 1'b0};
					quo_q <= '0;
					step_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= r_div;
					num_q <= n_div;
					quo_q <= q_div;
					step_q <= step_q + 1'b1;
					if (step_q == DIV_CNT_W'(DIV_CYC - 1)) state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (pick_b_q) begin
						bx_q <= use_y_q ? other : edge_q;
						by_q <= use_y_q ? edge_q : other;
					end else begin
						ax_q <= use_y_q ? other : edge_q;
						ay_q <= use_y_q ? edge_q : other;
					end
					rnd_q <= rnd_q + 1'b1;
					state_q <= ST_CLASS;
				end
				ST_PUSH: begin
					if (!line_full) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign seg_stall = (state_q != ST_IDLE);
	assign line_valid = (state_q == ST_PUSH);
	assign line = line_q;

endmodule

// ===== rtl/clr_queue.sv =====
module clr_queue import clr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  line_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output line_t pop_data
);

	line_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/clr_walk.sv =====
module clr_walk import clr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  line_valid,
	input  line_t line,
	output logic  line_pop,
	output logic  pix_valid,
	input  logic  pix_stall,
	output pix_t  pix
);

	logic                    busy_q, out_valid_q;
	logic [PIX_W-1:0]        px_q, py_q, qx_q, qy_q, dx_q, ady_q, cnt_q;
	logic                    sx_neg_q, sy_neg_q;
	logic signed [ERR_W-1:0] err_q;
	pix_t                    out_q;

	logic                    adv, done, step_x, step_y;
	logic signed [ERR_W:0]   e2;
	logic signed [ERR_W-1:0] err_n;
	logic [PIX_W-1:0]        ldx, ldy;

	always_comb begin
		adv = busy_q && (!out_valid_q || !pix_stall);
		done = (px_q == qx_q && py_q == qy_q) || (&cnt_q);
		e2 = {err_q, 1'b0};
		step_x = (e2 >= -$signed({(ERR_W-PIX_W+1)'(0), ady_q}));
		step_y = (e2 <= $signed({(ERR_W-PIX_W+1)'(0), dx_q}));
		err_n = err_q;
		if (step_x) err_n = err_n - $signed({(ERR_W-PIX_W)'(0), ady_q});
		if (step_y) err_n = err_n + $signed({(ERR_W-PIX_W)'(0), dx_q});
		ldx = (line.qx > line.px) ? line.qx - line.px : line.px - line.qx;
		ldy = (line.qy > line.py) ? line.qy - line.py : line.py - line.qy;
	end

	assign line_pop = !busy_q && line_valid;

	always_ff @(posedge clk) begin
		if (line_pop) begin
			px_q <= line.px;
			py_q <= line.py;
			qx_q <= line.qx;
			qy_q <= line.qy;
			dx_q <= ldx;
			ady_q <= ldy;
			sx_neg_q <= !(line.px < line.qx);
			sy_neg_q <= !(line.py < line.qy);
			err_q <= $signed({(ERR_W-PIX_W)'(0), ldx}) - $signed({(ERR_W-PIX_W)'(0), ldy});
			cnt_q <= '0;
		end else if (adv) begin
			out_q <= '{pixel_x: px_q, pixel_y: py_q, last_pixel: done};
			if (step_x) px_q <= sx_neg_q ? px_q - 1'b1 : px_q + 1'b1;
			if (step_y) py_q <= sy_neg_q ? py_q - 1'b1 : py_q + 1'b1;
			err_q <= err_n;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (line_pop) busy_q <= 1'b1;
			else if (adv && done) busy_q <= 1'b0;
			if (adv) out_valid_q <= 1'b1;
			else if (!pix_stall) out_valid_q <= 1'b0;
		end
	end

	assign pix_valid = out_valid_q;
	assign pix = out_q;

endmodule

// ===== rtl/clipped_line_rasterizer.sv =====
// Line segment rasterizer with viewport clipping.
// Input channel seg/seg_valid/seg_stall: one segment per transfer, endpoints
// signed Q12.4. Output channel pix/pix_valid/pix_stall: one pixel per transfer,
// last_pixel set on the final pixel of a segment; rejected segments give none.
// The clip unit takes one segment at a time. Each clip round steps through
// classify, multiply, prepare, a 2-bit-per-cycle divider and update; a
// segment needs 0 to CLIP_ROUNDS rounds. Clipped lines pass through a
// 4-entry queue to the walker, which loads a line and then emits one pixel
// per cycle while pix_stall is low, so clipping of the next segment
// overlaps the walk of the previous one.
// A first pixel passes the queue, the walker's line and output registers.
// pix_stall holds the output register and the walker; the queue then fills
// and the clip unit waits, raising seg_stall.
// arst_n empties the queue and returns both units to idle.
module clipped_line_rasterizer import clr_pkg::*; #(
	parameter int VIEW_WIDTH  = VIEW_WIDTH_DEF,
	parameter int VIEW_HEIGHT = VIEW_HEIGHT_DEF,
	parameter int CLIP_ROUNDS = CLIP_ROUNDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic seg_valid,
	output logic seg_stall,
	input  seg_t seg,
	output logic pix_valid,
	input  logic pix_stall,
	output pix_t pix
);

	logic  cl_valid, q_full, q_ne, q_pop;
	line_t cl_line, q_line;

	clr_clip #(
		.VIEW_WIDTH(VIEW_WIDTH),
		.VIEW_HEIGHT(VIEW_HEIGHT),
		.CLIP_ROUNDS(CLIP_ROUNDS)
	) u_clip (
		.clk(clk),
		.arst_n(arst_n),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.seg(seg),
		.line_valid(cl_valid),
		.line_full(q_full),
		.line(cl_line)
	);

	clr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(cl_valid),
		.push_data(cl_line),
		.full(q_full),
		.pop(q_pop),
		.not_empty(q_ne),
		.pop_data(q_line)
	);

	clr_walk u_walk (
		.clk(clk),
		.arst_n(arst_n),
		.line_valid(q_ne),
		.line(q_line),
		.line_pop(q_pop),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix)
	);

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	import clr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW = VIEW_WIDTH_DEF;
	localparam int VH = VIEW_HEIGHT_DEF;
	localparam int ROUNDS = CLIP_ROUNDS_DEF;
	localparam int WATCH_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic seg_valid = 1'b0;
	logic seg_stall;
	seg_t seg = '0;
	logic pix_valid;
	logic pix_stall = 1'b0;
	pix_t pix;

	pix_t pixel_queue[$];
	int errors = 0;
	int idle_cycles = 0;
	int hold_off = 0;
	bit stall_random = 1'b1;

	clipped_line_rasterizer DUT (
		.clk(clk), .arst_n(arst_n), .seg_valid(seg_valid), .seg_stall(seg_stall),
		.seg(seg), .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix)
	);

	always #1 clk = ~clk;

	function automatic int short_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	function automatic int unsigned region(longint x, longint y);
		int unsigned c;
		c = 0;
		if (x < 0) c |= OC_LEFT;
		else if (x > (VW - 1) * 16) c |= OC_RIGHT;
		if (y < 0) c |= OC_TOP;
		else if (y > (VH - 1) * 16) c |= OC_BOTTOM;
		return c;
	endfunction

	function automatic longint div_nearest(longint n, longint d);
		longint an, ad, q;
		an = n < 0 ? -n : n;
		ad = d < 0 ? -d : d;
		q = (2 * an + ad) / (2 * ad);
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	task automatic predict_pixels(input seg_t s);
		longint ax, ay, bx, by, nx, ny;
		int unsigned c0, c1, sel;
		int px, py, qx, qy, dx, dy, sx, sy, err, e2, n;
		bit ok, done;
		pix_t p;
		ax = s.start_x; ay = s.start_y; bx = s.end_x; by = s.end_y;
		ok = 1'b0;
		for (int r = 0; r < ROUNDS; r++) begin
			c0 = region(ax, ay);
			c1 = region(bx, by);
			if ((c0 | c1) == 0) begin
				ok = 1'b1;
				break;
			end
			if ((c0 & c1) != 0) break;
			sel = c0 != 0 ? c0 : c1;
			if ((sel & (OC_BOTTOM | OC_TOP)) != 0) begin
				if (by == ay) break;
				ny = (sel & OC_BOTTOM) != 0 ? (VH - 1) * 16 : 0;
				nx = ax + div_nearest((bx - ax) * (ny - ay), by - ay);
			end else begin
				if (bx == ax) break;
				nx = (sel & OC_RIGHT) != 0 ? (VW - 1) * 16 : 0;
				ny = ay + div_nearest((by - ay) * (nx - ax), bx - ax);
			end
			if (c0 != 0) begin
				ax = nx; ay = ny;
			end else begin
				bx = nx; by = ny;
			end
		end
		if (!ok) return;
		px = (ax + 8) / 16; py = (ay + 8) / 16;
		qx = (bx + 8) / 16; qy = (by + 8) / 16;
		dx = qx > px ? qx - px : px - qx;
		dy = -(qy > py ? qy - py : py - qy);
		sx = px < qx ? 1 : -1;
		sy = py < qy ? 1 : -1;
		err = dx + dy;
		n = 0;
		forever begin
			done = (px == qx && py == qy) || n == 63;
			p.pixel_x = px[5:0];
			p.pixel_y = py[5:0];
			p.last_pixel = done;
			pixel_queue.push_back(p);
			n++;
			if (done) break;
			e2 = 2 * err;
			if (e2 >= dy) begin
				err += dy; px += sx;
			end
			if (e2 <= dx) begin
				err += dx; py += sy;
			end
		end
	endtask

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task automatic send_segment(input seg_t s);
		int gap;
		gap = short_gap();
		if (gap > 0) begin
			seg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg <= s;
		seg_valid <= 1'b1;
		predict_pixels(s);
		do @(posedge clk); while (seg_stall);
	endtask

	function automatic seg_t make_seg(int x0, int y0, int x1, int y1);
		seg_t s;
		s.start_x = IN_W'(x0); s.start_y = IN_W'(y0);
		s.end_x = IN_W'(x1); s.end_y = IN_W'(y1);
		return s;
	endfunction

	function automatic int near_view();
		return $urandom_range(0, 1) ? $urandom_range(0, 1008) : $urandom_range(0, 2400) - 700;
	endfunction

	task automatic test_directed();
		send_segment(make_seg(0, 0, 1008, 1008));
		send_segment(make_seg(1008, 0, 0, 1008));
		send_segment(make_seg(100, 100, 100, 100));
		send_segment(make_seg(-32768, -32768, 32767, 32767));
		send_segment(make_seg(32767, -32768, -32768, 32767));
		send_segment(make_seg(-32768, 500, 32767, 500));
		send_segment(make_seg(500, -32768, 500, 32767));
		send_segment(make_seg(-100, -100, -50, 2000));
		send_segment(make_seg(2000, 10, 3000, 500));
		send_segment(make_seg(-200, 100, 2000, 900));
		send_segment(make_seg(1200, 900, -300, -150));
		send_segment(make_seg(7, 8, 24, 40));
		send_segment(make_seg(8, 8, 1000, 24));
		send_segment(make_seg(-8, 500, 1016, 500));
		send_segment(make_seg(-16, -16, 1100, 1050));
		send_segment(make_seg(-1000, 500, 500, -1000));
		send_segment(make_seg(-1, -1, 1009, 1009));
		send_segment(make_seg(300, 1009, 300, 5000));
	endtask

	task automatic test_random();
		int k;
		for (int i = 0; i < 180; i++) begin
			k = $urandom_range(0, 9);
			if (k < 6)
				send_segment(make_seg(near_view(), near_view(), near_view(), near_view()));
			else if (k < 8)
				send_segment(make_seg($urandom, $urandom, $urandom, $urandom));
			else
				send_segment(make_seg($urandom_range(0, 1008), $urandom_range(0, 1008),
					$urandom_range(0, 1008), $urandom_range(0, 1008)));
		end
	endtask

	task automatic test_backpressure();
		hold_off <= 300;
		for (int i = 0; i < 12; i++)
			send_segment(make_seg($urandom_range(0, 1008), 0, $urandom_range(0, 1008), 1008));
	endtask

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			pix_stall <= 1'b1;
		end else if (stall_random && $urandom_range(0, 3) == 0) begin
			pix_stall <= 1'b1;
		end else begin
			pix_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		pix_t want;
		if (arst_n && pix_valid && !pix_stall) begin
			if (pixel_queue.size() == 0) begin
				report("unexpected pixel x", pix.pixel_x, -1);
			end else begin
				want = pixel_queue.pop_front();
				if (pix.pixel_x !== want.pixel_x) report("pixel_x", pix.pixel_x, want.pixel_x);
				if (pix.pixel_y !== want.pixel_y) report("pixel_y", pix.pixel_y, want.pixel_y);
				if (pix.last_pixel !== want.last_pixel)
					report("last_pixel", pix.last_pixel, want.last_pixel);
			end
		end
	end

	always @(posedge clk) begin
		if ((seg_valid && !seg_stall) || (pix_valid && !pix_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCH_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		seg_valid <= 1'b0;
		while (pixel_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pixel_queue.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule
